FILE: hdl/gait_phase_generator_top_assert.svh
// Assertion macros shared by the gait phase generator checkers.
// No dependencies; include by bare file name.
`ifndef GAIT_PHASE_GENERATOR_TOP_ASSERT_SVH
`define GAIT_PHASE_GENERATOR_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define GPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define GPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/gpg_pkg.sv
// Package of the gait phase generator: widths, codes, offset table, shared types.
// No dependencies.
package gpg_pkg;

  localparam int SPEED_W   = 16;
  localparam int RATE_W    = 12;
  localparam int LEN_W     = 11;
  localparam int IDX_W     = 10;
  localparam int PHASE_W   = 16;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int QUOT_W    = 48;
  localparam int ROOT_W    = 24;
  localparam int SQREM_W   = 27;
  localparam int CNT_W     = 6;
  localparam int PROFILE_DEPTH_DEF = 1024;

  // Reciprocal of three scaled by 2^19, rounded up.
  localparam logic [17:0] RECIP3 = 18'd174763;
  localparam logic [PHASE_W-1:0] WALK_KNEE = 16'd49152;
  localparam logic [PHASE_W-1:0] HALF_CYCLE = 16'd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIT_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STANCE_SPEED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_RATE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_LENGTH = 2'd3;

  localparam logic [MODE_W-1:0] GAIT_PASSIVE = 3'd0;
  localparam logic [MODE_W-1:0] GAIT_STAND   = 3'd1;
  localparam logic [MODE_W-1:0] GAIT_WALK    = 3'd2;
  localparam logic [MODE_W-1:0] GAIT_TROT    = 3'd3;
  localparam logic [MODE_W-1:0] GAIT_CANTER  = 3'd4;
  localparam logic [MODE_W-1:0] GAIT_GALLOP  = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]         gait_mode;
    logic signed [SPEED_W-1:0] stance_speed;
    logic [RATE_W-1:0]         tick_rate;
    logic [LEN_W-1:0]          profile_length;
  } gpg_cfg_t;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       rate_init;
    logic       leg_a;
    logic       leg_b;
    logic       write;
    logic [1:0] leg;
  } gpg_cmd_t;

  typedef struct packed {
    logic ok;
    logic out_free;
  } gpg_status_t;

  // Leg phase offsets in 1/65536 of a cycle; legs are FL, FR, RL, RR.
  function automatic logic [PHASE_W-1:0] leg_offset(input logic [MODE_W-1:0] mode,
                                                    input logic [1:0] leg);
    logic [PHASE_W-1:0] off;
    off = '0;
    case (mode)
      GAIT_WALK: begin
        case (leg)
          2'd1:    off = 16'd32768;
          2'd2:    off = 16'd16384;
          2'd3:    off = 16'd49152;
          default: off = 16'd0;
        endcase
      end
      GAIT_TROT: begin
        case (leg)
          2'd0, 2'd3: off = 16'd32768;
          default:    off = 16'd0;
        endcase
      end
      GAIT_CANTER: begin
        case (leg)
          2'd1:    off = 16'd19661;
          2'd2:    off = 16'd45875;
          default: off = 16'd0;
        endcase
      end
      GAIT_GALLOP: begin
        case (leg)
          2'd1:    off = 16'd6554;
          2'd2:    off = 16'd39322;
          2'd3:    off = 16'd32768;
          default: off = 16'd0;
        endcase
      end
      default: off = '0;
    endcase
    return off;
  endfunction

endpackage

FILE: hdl/gpg_if.sv
// Channel interfaces of the gait phase generator: speed input and phase result.
// Depends on gpg_pkg.
interface gpg_in_if;
  import gpg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] desired_speed;
  modport source (output valid, output desired_speed, input ready);
  modport sink (input valid, input desired_speed, output ready);
endinterface

interface gpg_out_if;
  import gpg_pkg::*;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [IDX_W-1:0]   front_left_index;
  logic [IDX_W-1:0]   front_right_index;
  logic [IDX_W-1:0]   rear_left_index;
  logic [IDX_W-1:0]   rear_right_index;
  logic [SPEED_W-1:0] step_scale;
  modport source (output valid, output valid_res, output front_left_index,
                  output front_right_index, output rear_left_index,
                  output rear_right_index, output step_scale, input ready);
  modport sink (input valid, input valid_res, input front_left_index,
                input front_right_index, input rear_left_index,
                input rear_right_index, input step_scale, output ready);
endinterface

FILE: hdl/gpg_cfg.sv
// Configuration register file of the gait phase generator.
// Depends on gpg_pkg.
module gpg_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gpg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gpg_pkg::SPEED_W-1:0]    cfg_wdata,
  output gpg_pkg::gpg_cfg_t              cfg
);
  import gpg_pkg::*;

  gpg_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_GAIT_MODE:      cfg_nxt.gait_mode      = cfg_wdata[MODE_W-1:0];
        CFG_STANCE_SPEED:   cfg_nxt.stance_speed   = cfg_wdata;
        CFG_LOOP_RATE:      cfg_nxt.tick_rate      = cfg_wdata[RATE_W-1:0];
        CFG_PROFILE_LENGTH: cfg_nxt.profile_length = cfg_wdata[LEN_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gait_mode      <= GAIT_PASSIVE;
      cfg_r.stance_speed   <= 16'sd4096;
      cfg_r.tick_rate      <= 12'd20;
      cfg_r.profile_length <= 11'd1024;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/gpg_ctrl.sv
// Sequencer of the gait phase generator: steps the shared divider and root unit,
// walks the four legs and writes the result. Depends on gpg_pkg.
module gpg_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gpg_pkg::gpg_status_t  st,
  output gpg_pkg::gpg_cmd_t     cmd
);
  import gpg_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIV   = 9'b000000010,
    S_SQI   = 9'b000000100,
    S_SQRT  = 9'b000001000,
    S_RTI   = 9'b000010000,
    S_RATE  = 9'b000100000,
    S_LEGA  = 9'b001000000,
    S_LEGB  = 9'b010000000,
    S_WRITE = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       leg_r, leg_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    leg_nxt   = leg_r;
    cmd       = '0;
    cmd.leg   = leg_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!st.ok) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(QUOT_W - 1)) state_nxt = S_SQI;
        end
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) state_nxt = S_RTI;
      end
      S_RTI: begin
        cmd.rate_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_RATE;
      end
      S_RATE: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          leg_nxt   = '0;
          state_nxt = S_LEGA;
        end
      end
      S_LEGA: begin
        cmd.leg_a = 1'b1;
        state_nxt = S_LEGB;
      end
      S_LEGB: begin
        cmd.leg_b = 1'b1;
        leg_nxt   = leg_r + 1'b1;
        state_nxt = (leg_r == 2'd3) ? S_WRITE : S_LEGA;
      end
      S_WRITE: begin
        if (st.out_free) begin
          cmd.write = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      leg_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      leg_r   <= leg_nxt;
    end
  end

endmodule

FILE: hdl/gpg_dp.sv
// Datapath of the gait phase generator: shared restoring divider and square root,
// leg phase and index unit, stored phase and output register. Depends on gpg_pkg.
module gpg_dp #(
  parameter int PROFILE_DEPTH = gpg_pkg::PROFILE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gpg_pkg::gpg_cfg_t             cfg,
  input  gpg_pkg::gpg_cmd_t             cmd,
  output gpg_pkg::gpg_status_t          st,
  input  logic signed [gpg_pkg::SPEED_W-1:0] in_speed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_valid_res,
  output logic [gpg_pkg::IDX_W-1:0]     out_fl,
  output logic [gpg_pkg::IDX_W-1:0]     out_fr,
  output logic [gpg_pkg::IDX_W-1:0]     out_rl,
  output logic [gpg_pkg::IDX_W-1:0]     out_rr,
  output logic [gpg_pkg::SPEED_W-1:0]   out_step
);
  import gpg_pkg::*;

  localparam logic [LEN_W-1:0] LEN_MAX =
      (PROFILE_DEPTH > 2047) ? 11'd2047 : LEN_W'(PROFILE_DEPTH);

  logic [QUOT_W-1:0]   sh_r;
  logic [SQREM_W-1:0]  rem_r;
  logic [SPEED_W-1:0]  dvs_r;
  logic [ROOT_W-1:0]   root_r;
  logic                ok_r;
  logic [PHASE_W-1:0]  phase_r;
  logic [PHASE_W-1:0]  pm_r;
  logic [IDX_W-1:0]    idx_r [4];
  logic                out_valid_r;
  logic                res_r;
  logic [IDX_W-1:0]    fl_r, fr_r, rl_r, rr_r;
  logic [SPEED_W-1:0]  step_r;

  // Input sign and magnitude; the ratio is positive when the speeds differ in sign.
  logic                sp_neg, sp_zero, vo_neg, vo_zero, in_ok;
  logic [SPEED_W-1:0]  avd, avo;
  always_comb begin
    sp_neg  = in_speed[SPEED_W-1];
    sp_zero = (in_speed == '0);
    vo_neg  = cfg.stance_speed[SPEED_W-1];
    vo_zero = (cfg.stance_speed == '0);
    in_ok   = !sp_zero && !vo_zero && (sp_neg != vo_neg);
    avd     = sp_neg ? SPEED_W'(-in_speed) : in_speed;
    avo     = vo_neg ? SPEED_W'(-cfg.stance_speed) : cfg.stance_speed;
  end

  // One restoring division step.
  logic [SPEED_W:0] div_t, div_d;
  logic             div_ge;
  always_comb begin
    div_t  = {rem_r[SPEED_W-1:0], sh_r[QUOT_W-1]};
    div_d  = {1'b0, dvs_r};
    div_ge = (div_t >= div_d);
  end

  // One digit of the square root.
  logic [SQREM_W-1:0] sq_t, sq_trial;
  logic               sq_ge;
  always_comb begin
    sq_t     = {rem_r[SQREM_W-3:0], sh_r[QUOT_W-1 -: 2]};
    sq_trial = {1'b0, root_r, 2'b01};
    sq_ge    = (sq_t >= sq_trial);
  end

  // Leg phase with the walk remap.
  logic [PHASE_W-1:0] p_raw, p_map;
  logic [34:0]        p_third;
  always_comb begin
    p_raw   = phase_r + leg_offset(cfg.gait_mode, cmd.leg);
    p_third = 35'({p_raw, 1'b0}) * 35'(RECIP3);
    if (cfg.gait_mode != GAIT_WALK) begin
      p_map = p_raw;
    end else if (p_raw < WALK_KNEE) begin
      p_map = p_third[34:19];
    end else begin
      p_map = HALF_CYCLE + PHASE_W'({p_raw - WALK_KNEE, 1'b0});
    end
  end

  // Leg start index from the mapped phase and the effective table length.
  logic [LEN_W-1:0]   len, len_m1, q_idx;
  logic [26:0]        prod;
  logic [IDX_W-1:0]   idx_val;
  logic               gait_legs;
  always_comb begin
    len = (cfg.profile_length == '0) ? LEN_W'(1) : cfg.profile_length;
    if (len > LEN_MAX) len = LEN_MAX;
    len_m1    = len - 1'b1;
    prod      = 27'(pm_r) * 27'(len);
    q_idx     = (prod[26:16] > len_m1) ? len_m1 : prod[26:16];
    gait_legs = (cfg.gait_mode == GAIT_WALK) || (cfg.gait_mode == GAIT_TROT) ||
                (cfg.gait_mode == GAIT_CANTER) || (cfg.gait_mode == GAIT_GALLOP);
    idx_val   = gait_legs ? q_idx[IDX_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sh_r  <= {avd, 32'b0};
      rem_r <= '0;
      dvs_r <= avo;
      ok_r  <= in_ok;
    end
    if (cmd.div_step) begin
      sh_r  <= {sh_r[QUOT_W-2:0], div_ge};
      rem_r <= SQREM_W'(div_ge ? div_t - div_d : div_t);
    end
    if (cmd.sqrt_init) begin
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      sh_r   <= {sh_r[QUOT_W-3:0], 2'b00};
      rem_r  <= sq_ge ? sq_t - sq_trial : sq_t;
      root_r <= {root_r[ROOT_W-2:0], sq_ge};
    end
    if (cmd.rate_init) begin
      sh_r  <= {root_r, 24'b0};
      rem_r <= '0;
      dvs_r <= SPEED_W'(cfg.tick_rate);
    end
    if (cmd.leg_a) pm_r <= p_map;
    if (cmd.leg_b) idx_r[cmd.leg] <= idx_val;
    if (cmd.write) begin
      res_r  <= ok_r;
      fl_r   <= ok_r ? idx_r[0] : '0;
      fr_r   <= ok_r ? idx_r[1] : '0;
      rl_r   <= ok_r ? idx_r[2] : '0;
      rr_r   <= ok_r ? idx_r[3] : '0;
      step_r <= !ok_r ? '0 :
                (root_r[ROOT_W-1 -: 4] != '0) ? '1 : root_r[19:4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.write && ok_r && (cfg.tick_rate != '0)) begin
        phase_r <= phase_r + sh_r[PHASE_W-1:0];
      end
      if (cmd.write) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign st.ok       = ok_r;
  assign st.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_valid_res = res_r;
  assign out_fl        = fl_r;
  assign out_fr        = fr_r;
  assign out_rl        = rl_r;
  assign out_rr        = rr_r;
  assign out_step      = step_r;

endmodule

FILE: hdl/gait_phase_generator_top.sv
// Top level of the gait phase generator: configuration registers, sequencer, datapath.
// Depends on gpg_pkg, gpg_if, gpg_cfg, gpg_ctrl and gpg_dp.
//
// One speed transfer on in_ch yields exactly one result transfer on out_ch.
// in_ch carries desired_speed (signed Q4.12); out_ch carries valid_res, four
// swing table start indices and step_scale (unsigned Q4.12).
// Registers are written through cfg_we, cfg_idx and cfg_wdata while idle; the user
// must see to that, as the block itself does not enforce it. With a positive speed
// ratio a result waits on out_ch after 48 divider steps, 24 root steps, 24 steps of
// the phase-advance division and the states S_LEGA and S_LEGB for each leg, all on
// one shift-subtract unit; else the sequencer goes from the divider to its write.
// One item is in work at a time: a new speed is taken only back in idle.
// in_ch.ready is high only while the sequencer is idle. A finished result sits
// in the output register; the next item is accepted and worked on while it
// waits, and the sequencer holds before its write until out_ch is free.
// Reset (rst_n low at a clock edge) loads the register defaults, zeroes the
// stored phase and empties the output register.
module gait_phase_generator_top #(
  parameter int PROFILE_DEPTH = gpg_pkg::PROFILE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gpg_in_if.sink                        in_ch,
  gpg_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [gpg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [gpg_pkg::SPEED_W-1:0]   cfg_wdata
);
  import gpg_pkg::*;

  gpg_cfg_t    cfg;
  gpg_cmd_t    cmd;
  gpg_status_t st;

  gpg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  gpg_dp #(.PROFILE_DEPTH(PROFILE_DEPTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .st            (st),
    .in_speed      (in_ch.desired_speed),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_valid_res (out_ch.valid_res),
    .out_fl        (out_ch.front_left_index),
    .out_fr        (out_ch.front_right_index),
    .out_rl        (out_ch.rear_left_index),
    .out_rr        (out_ch.rear_right_index),
    .out_step      (out_ch.step_scale)
  );

endmodule

FILE: hdl/gpg_checker.sv
// Port-level checker of the gait phase generator and its bind to the top level.
// Depends on gpg_pkg and gait_phase_generator_top_assert.svh.
`include "gait_phase_generator_top_assert.svh"

module gpg_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_valid_res,
  input logic [gpg_pkg::IDX_W-1:0]     out_fl,
  input logic [gpg_pkg::IDX_W-1:0]     out_fr,
  input logic [gpg_pkg::IDX_W-1:0]     out_rl,
  input logic [gpg_pkg::IDX_W-1:0]     out_rr,
  input logic [gpg_pkg::SPEED_W-1:0]   out_step
);
  import gpg_pkg::*;

  // A stalled result stays valid and keeps its step scale and valid flag.
  `GPG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_step) && $stable(out_valid_res), "result changed while stalled")

  // An invalid result carries zeros in every field.
  `GPG_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_valid && !out_valid_res, out_step == '0 && out_fl == '0 && out_fr == '0 && out_rl == '0 && out_rr == '0, "invalid result has nonzero fields")

  // The block works on one item at a time, so it is busy right after a transfer.
  `GPG_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted twice in a row")

endmodule

bind gait_phase_generator_top gpg_port_checker u_gpg_port_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_valid_res (out_ch.valid_res),
  .out_fl        (out_ch.front_left_index),
  .out_fr        (out_ch.front_right_index),
  .out_rl        (out_ch.rear_left_index),
  .out_rr        (out_ch.rear_right_index),
  .out_step      (out_ch.step_scale)
);

FILE: test/gpg_checker.sv
// Checker of the gait phase generator: predicts each result from the speed transfers
// and configuration writes it observes and compares it with the result transfers.
// Depends on gpg_pkg and gpg_if.
module gpg_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  gpg_in_if                             in_ch,
  gpg_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [gpg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [gpg_pkg::SPEED_W-1:0]   cfg_wdata,
  output int                            fail_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import gpg_pkg::*;

  typedef struct packed {
    logic             valid_res;
    logic [IDX_W-1:0] fl;
    logic [IDX_W-1:0] fr;
    logic [IDX_W-1:0] rl;
    logic [IDX_W-1:0] rr;
    logic [15:0]      scale;
  } leg_result_t;

  logic [MODE_W-1:0]  mode_q;
  logic [15:0]        stance_q;
  logic [RATE_W-1:0]  rate_q;
  logic [LEN_W-1:0]   len_q;
  logic [PHASE_W-1:0] phase_q;
  leg_result_t        expected_results[$];

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [PHASE_W-1:0] gait_offset(input logic [MODE_W-1:0] m,
                                                     input int leg);
    case (m)
      GAIT_WALK:   return (leg == 1) ? 16'd32768 : (leg == 2) ? 16'd16384 :
                          (leg == 3) ? 16'd49152 : 16'd0;
      GAIT_TROT:   return (leg == 0 || leg == 3) ? 16'd32768 : 16'd0;
      GAIT_CANTER: return (leg == 1) ? 16'd19661 : (leg == 2) ? 16'd45875 : 16'd0;
      GAIT_GALLOP: return (leg == 1) ? 16'd6554 : (leg == 2) ? 16'd39322 :
                          (leg == 3) ? 16'd32768 : 16'd0;
      default:     return 16'd0;
    endcase
  endfunction

  // Works out one result and, for a valid result with a nonzero rate, advances the stored phase.
  function automatic leg_result_t predict_legs(input logic [15:0] speed_bits);
    leg_result_t res;
    longint vd, vo, ad, ao;
    logic [63:0] root, scale, len, p, idx;
    logic [9:0] legs[4];
    res = '0;
    vd = -longint'($signed(speed_bits));
    vo = longint'($signed(stance_q));
    if (vd == 0 || vo == 0 || ((vd < 0) != (vo < 0))) return res;
    ad = vd < 0 ? -vd : vd;
    ao = vo < 0 ? -vo : vo;
    root = floor_sqrt((64'(ad) << 32) / 64'(ao));
    scale = root >> 4;
    if (scale > 65535) scale = 65535;
    len = len_q;
    if (len < 1) len = 1;
    if (len > PROFILE_DEPTH_DEF) len = PROFILE_DEPTH_DEF;
    for (int k = 0; k < 4; k++) begin
      legs[k] = '0;
      if (mode_q >= GAIT_WALK && mode_q <= GAIT_GALLOP) begin
        p = (64'(phase_q) + gait_offset(mode_q, k)) & 64'hFFFF;
        if (mode_q == GAIT_WALK)
          p = (p < 49152) ? (p * 2) / 3 : 32768 + 2 * (p - 49152);
        idx = (p * len) >> 16;
        if (idx > len - 1) idx = len - 1;
        legs[k] = idx[9:0];
      end
    end
    res.valid_res = 1'b1;
    res.fl = legs[0];
    res.fr = legs[1];
    res.rl = legs[2];
    res.rr = legs[3];
    res.scale = scale[15:0];
    if (rate_q != 0) phase_q = phase_q + PHASE_W'(root / 64'(rate_q));
    return res;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    leg_result_t seen, want;
    if (!rst_n) begin
      mode_q <= GAIT_PASSIVE;
      stance_q <= 16'd4096;
      rate_q <= 12'd20;
      len_q <= 11'd1024;
      phase_q = '0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_GAIT_MODE:      mode_q <= cfg_wdata[MODE_W-1:0];
          CFG_STANCE_SPEED:   stance_q <= cfg_wdata;
          CFG_LOOP_RATE:      rate_q <= cfg_wdata[RATE_W-1:0];
          CFG_PROFILE_LENGTH: len_q <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_results = {expected_results, predict_legs(in_ch.desired_speed)};
      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.valid_res, out_ch.front_left_index, out_ch.front_right_index,
                 out_ch.rear_left_index, out_ch.rear_right_index, out_ch.step_scale};
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result transfer: %p", seen);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            if (fail_count < 10) $display("Mismatch: expected %p, got %p", want, seen);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: test/gait_phase_generator_top_tb.sv
// Top of the gait phase generator testbench: clock, reset, speed stimulus,
// configuration phases, result back-pressure and the verdict.
// Depends on gpg_pkg, gpg_if, gpg_checker and the block itself.
module gait_phase_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gpg_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [SPEED_W-1:0] cfg_wdata;
  int fail_count;
  int pending_count;
  bit steady_phase;
  bit hold_results;

  gpg_in_if in_ch ();
  gpg_out_if out_ch ();

  gait_phase_generator_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  gpg_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("FAIL gait_phase_generator_top");
    $finish;
  end

  // Receiver: random stalls, none during the steady phase, one long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) out_ch.ready <= 1'b0;
      else if (steady_phase) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(99) >= 27);
    end
  end

  // Leaves the write enable high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Leaves valid high after the transfer; the next call or the caller drives it next.
  task automatic send_speed(input logic [15:0] speed);
    if (!steady_phase) begin
      while ($urandom_range(99) < 27) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.desired_speed <= speed;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Waits for every result, then lets the sequencer settle before a register write.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [15:0] random_speed();
    case ($urandom_range(5))
      0: return 16'($urandom_range(65535));
      1: return 16'(-$signed(16'($urandom_range(8192))));
      2: return 16'($urandom_range(64));
      3: return 16'($urandom_range(65535) | 16'h8000);
      default: return 16'(-$signed(16'($urandom_range(32767))));
    endcase
  endfunction

  initial begin
    logic [15:0] stances[6];
    logic [11:0] rates[5];
    logic [10:0] lengths[6];
    logic [15:0] directed[10];
    int sent;
    stances = '{16'd4096, 16'hF000, 16'd1, 16'h8000, 16'h7FFF, 16'd0};
    rates = '{12'd20, 12'd1, 12'd4095, 12'd0, 12'd300};
    lengths = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd1025, 11'd37};
    directed = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'hF000,
                 16'h1000, 16'hC000, 16'h4000, 16'hFFF0};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.desired_speed = '0;
    steady_phase = 1'b0;
    hold_results = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme speeds across every gait code, including the unused ones.
    for (int m = 0; m < 8; m++) begin
      drain_block();
      write_reg(CFG_GAIT_MODE, 16'(m));
      cfg_we <= 1'b0;
      for (int k = 0; k < 3; k++) send_speed(directed[(m + k * 3) % 10]);
    end

    sent = 0;
    for (int phase_i = 0; phase_i < 30; phase_i++) begin
      drain_block();
      write_reg(CFG_GAIT_MODE, 16'($urandom_range(7)));
      write_reg(CFG_STANCE_SPEED,
                ($urandom_range(2) == 0) ? 16'($urandom_range(65535))
                                         : stances[phase_i % 6]);
      write_reg(CFG_LOOP_RATE,
                ($urandom_range(1) == 0) ? 16'($urandom_range(4095)) : 16'(rates[phase_i % 5]));
      write_reg(CFG_PROFILE_LENGTH,
                ($urandom_range(1) == 0) ? 16'($urandom_range(2047))
                                         : 16'(lengths[phase_i % 6]));
      cfg_we <= 1'b0;
      steady_phase = (phase_i == 5);
      if (phase_i == 9) begin
        // Hold results back while offering more speeds, so the input stalls.
        fork
          begin
            hold_results = 1'b1;
            repeat (600) @(posedge clk);
            hold_results = 1'b0;
          end
          for (int k = 0; k < 6; k++) send_speed(random_speed());
        join
      end
      for (int k = 0; k < 50; k++) begin
        send_speed(random_speed());
        sent++;
      end
    end
    steady_phase = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS gait_phase_generator_top");
    end else begin
      $display("FAIL gait_phase_generator_top");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/gpg_pkg.sv
hdl/gpg_if.sv
hdl/gpg_cfg.sv
hdl/gpg_ctrl.sv
hdl/gpg_dp.sv
hdl/gait_phase_generator_top.sv
hdl/gpg_checker.sv
test/gpg_checker.sv
test/gait_phase_generator_top_tb.sv
